@@ rtl/ecg_rpeak_morph_detector_assert.svh @@
// ============================================================================
// ECG R-peak detector assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ============================================================================
`ifndef ECG_RPEAK_MORPH_DETECTOR_ASSERT_SVH
`define ECG_RPEAK_MORPH_DETECTOR_ASSERT_SVH
`ifndef SYNTH
`define ECGRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ECGRP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECGRP_ASSERT(lbl, clk, rstn, prop, msg)
`define ECGRP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/ecgrp_pkg.sv @@
// ============================================================================
// ECG R-peak detector package
// Field widths, status codes, state types and shared structs.
// ============================================================================
package ecgrp_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int THR_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int PEAK_IDX_W = 9;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int TICK_W     = 8;

  // transform value: |M| <= 61430, fits 18 bit signed; magnitude in 17 bits
  localparam int MT_W  = 18;
  localparam int MAG_W = 17;

  localparam logic [THR_W-1:0] THR_RESET = 12'd140;
  localparam int SCALE         = 10;
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;

  typedef enum logic [STATUS_W-1:0] {
    ST_LEARNING = 3'd0,
    ST_STORED   = 3'd1,
    ST_NO_PEAK  = 3'd2,
    ST_PEAK     = 3'd3,
    ST_OVERDUE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT
  } seq_state_t;

  typedef enum logic [2:0] {
    MT_IDLE,
    MT_WIN,
    MT_DIFF,
    MT_MUL,
    MT_OUT
  } mmt_state_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [TICK_W-1:0] tick;
  } tod_t;

  typedef struct packed {
    logic                   done;
    logic signed [MT_W-1:0] m;
  } mmt_rsp_t;

endpackage

@@ rtl/ecgrp_store.sv @@
// ============================================================================
// ECG R-peak detector sample store
// Single write port, single registered read port circular sample memory.
// ============================================================================
module ecgrp_store #(
  parameter int BUFFER_DEPTH = 512,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [ecgrp_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [ecgrp_pkg::SAMPLE_W-1:0] rd_data
);

  logic [ecgrp_pkg::SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [ecgrp_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ecgrp_tod.sv @@
// ============================================================================
// ECG R-peak detector time-of-day clock
// Tick / second / minute / hour counters advanced once per stored sample.
// ============================================================================
module ecgrp_tod #(
  parameter int TICKS_PER_SECOND = 200
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  output ecgrp_pkg::tod_t  tod
);

  ecgrp_pkg::tod_t tod_r, tod_nxt;

  always_comb begin
    tod_nxt = tod_r;
    if (adv) begin
      if (tod_r.tick == ecgrp_pkg::TICK_W'(TICKS_PER_SECOND - 1)) begin
        tod_nxt.tick = '0;
        if (tod_r.second == ecgrp_pkg::SEC_W'(ecgrp_pkg::SECS_PER_MIN - 1)) begin
          tod_nxt.second = '0;
          if (tod_r.minute == ecgrp_pkg::MIN_W'(ecgrp_pkg::MINS_PER_HOUR - 1)) begin
            tod_nxt.minute = '0;
            if (tod_r.hour == ecgrp_pkg::HOUR_W'(ecgrp_pkg::HOURS_PER_DAY - 1)) begin
              tod_nxt.hour = '0;
            end else begin
              tod_nxt.hour = tod_r.hour + 1'b1;
            end
          end else begin
            tod_nxt.minute = tod_r.minute + 1'b1;
          end
        end else begin
          tod_nxt.second = tod_r.second + 1'b1;
        end
      end else begin
        tod_nxt.tick = tod_r.tick + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r <= '0;
    end else begin
      tod_r <= tod_nxt;
    end
  end

  assign tod = tod_r;

endmodule

@@ rtl/ecgrp_mmt.sv @@
// ============================================================================
// ECG R-peak detector transform unit
// Computes one morphological transform value per request: walks the window
// through the store read port, then scales by 10 / HALF_WINDOW.
// ============================================================================
module ecgrp_mmt #(
  parameter int BUFFER_DEPTH = 512,
  parameter int HALF_WINDOW  = 4,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [AW-1:0]                  pos,
  input  logic [ecgrp_pkg::SAMPLE_W-1:0] rd_data,
  output logic [AW-1:0]                  rd_addr,
  output ecgrp_pkg::mmt_rsp_t            rsp
);

  localparam int MT_W   = ecgrp_pkg::MT_W;
  localparam int MAG_W  = ecgrp_pkg::MAG_W;
  localparam int SW     = ecgrp_pkg::SAMPLE_W;
  localparam int K_LAST = 2 * HALF_WINDOW + 1;
  localparam int KW     = $clog2(K_LAST + 1);
  // reciprocal ceil(2^SHIFT / HW): exact floor division for magnitudes < 2^MAG_W
  localparam int SHIFT  = MAG_W + $clog2(HALF_WINDOW);
  localparam int RW     = MAG_W + 2;
  localparam int PW     = MAG_W + RW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(HALF_WINDOW) - 64'd1) / 64'(HALF_WINDOW);
  localparam logic [RW-1:0] RECIP   = RECIP_FULL[RW-1:0];
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(BUFFER_DEPTH);
  localparam logic [AW:0]   HW_X    = (AW+1)'(HALF_WINDOW);

  ecgrp_pkg::mmt_state_t state_r, state_nxt;

  logic [AW-1:0]          addr_r, addr_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic signed [SW-1:0]   hi_r, hi_nxt, lo_r, lo_nxt, cen_r, cen_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;

  logic [AW:0]            pos_x, win_start;
  logic signed [SW-1:0]   v;
  logic signed [MT_W-1:0] d, x, m_val;
  logic [PW-1:0]          shifted;
  logic [MAG_W-1:0]       q;

  assign pos_x     = {1'b0, pos};
  assign win_start = (pos_x >= HW_X) ? (pos_x - HW_X) : (pos_x + DEPTH_X - HW_X);
  assign v         = $signed(rd_data);

  assign d = MT_W'(hi_r) + MT_W'(lo_r) - (MT_W'(cen_r) <<< 1);
  assign x = d * $signed(MT_W'(ecgrp_pkg::SCALE));

  assign shifted = prod_r >> SHIFT;
  assign q       = shifted[MAG_W-1:0];
  assign m_val   = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecgrp_pkg::MT_IDLE: begin
        if (go) begin
          state_nxt = ecgrp_pkg::MT_WIN;
        end
      end
      ecgrp_pkg::MT_WIN: begin
        if (k_r == KW'(K_LAST)) begin
          state_nxt = ecgrp_pkg::MT_DIFF;
        end
      end
      ecgrp_pkg::MT_DIFF: state_nxt = ecgrp_pkg::MT_MUL;
      ecgrp_pkg::MT_MUL:  state_nxt = ecgrp_pkg::MT_OUT;
      ecgrp_pkg::MT_OUT:  state_nxt = ecgrp_pkg::MT_IDLE;
      default:            state_nxt = ecgrp_pkg::MT_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    addr_nxt = addr_r;
    k_nxt    = k_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cen_nxt  = cen_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    prod_nxt = prod_r;
    case (state_r)
      ecgrp_pkg::MT_IDLE: begin
        addr_nxt = win_start[AW-1:0];
        k_nxt    = '0;
        hi_nxt   = '0;
        lo_nxt   = '0;
      end
      ecgrp_pkg::MT_WIN: begin
        k_nxt    = k_r + 1'b1;
        addr_nxt = (addr_r == AW'(BUFFER_DEPTH - 1)) ? '0 : addr_r + 1'b1;
        // read data trails the address through the registered store read port
        if (k_r != '0) begin
          if (v > hi_r) hi_nxt = v;
          if (v < lo_r) lo_nxt = v;
          if (k_r == KW'(HALF_WINDOW + 1)) cen_nxt = v;
        end
      end
      ecgrp_pkg::MT_DIFF: begin
        neg_nxt = x[MT_W-1];
        mag_nxt = x[MT_W-1] ? MAG_W'(-x) : MAG_W'(x);
      end
      ecgrp_pkg::MT_MUL: begin
        prod_nxt = PW'(mag_r) * PW'(RECIP);
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    rd_addr  = addr_r;
    rsp.done = (state_r == ecgrp_pkg::MT_OUT);
    rsp.m    = m_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecgrp_pkg::MT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    k_r    <= k_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    cen_r  <= cen_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
  end

endmodule

@@ rtl/ecg_rpeak_morph_detector.sv @@
// ============================================================================
// ECG R-peak detector, multiscale morphological transform
// Store beats and learning-time scan beats: result registered in the cycle after
//   accept, busy stays low, so a beat can be taken every cycle.
// Scan beats: up to (SEARCH_SPAN+1) transforms, run one after another on the
//   shared transform unit, which walks each window through the single store
//   read port; busy high meanwhile.
// Results are single-cycle strobes on out_valid; the receiver cannot stall.
// Reset: synchronous, active low; clears control, clock and threshold (140).
//   Store contents are not cleared; learning covers the first pass.
// ============================================================================
`include "ecg_rpeak_morph_detector_assert.svh"

module ecg_rpeak_morph_detector #(
  parameter int BUFFER_DEPTH     = 512,
  parameter int HALF_WINDOW      = 4,
  parameter int SEARCH_SPAN      = 256,
  parameter int SEARCH_MARGIN    = 8,
  parameter int TICKS_PER_SECOND = 200
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic signed [ecgrp_pkg::SAMPLE_W-1:0] in_sample,
  output logic                             out_valid,
  output logic [ecgrp_pkg::STATUS_W-1:0]   out_status,
  output logic [ecgrp_pkg::PEAK_IDX_W-1:0] out_peak_index,
  output logic [ecgrp_pkg::HOUR_W-1:0]     out_hour_of_day,
  output logic [ecgrp_pkg::MIN_W-1:0]      out_minute_of_hour,
  output logic [ecgrp_pkg::SEC_W-1:0]      out_second_of_minute,
  output logic [ecgrp_pkg::TICK_W-1:0]     out_tick_of_second,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ecgrp_pkg::THR_W-1:0]      cfg_peak_threshold
);

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(SEARCH_SPAN + 1);
  localparam int MT_W = ecgrp_pkg::MT_W;
  localparam int MARG_MOD = SEARCH_MARGIN % BUFFER_DEPTH;
  localparam logic [AW:0] DEPTH_X = (AW+1)'(BUFFER_DEPTH);

  ecgrp_pkg::seq_state_t state_r, state_nxt;

  logic [AW-1:0]            wp_r, wp_nxt;
  logic                     learning_r, learning_nxt;
  logic                     wrapped_r, wrapped_nxt;
  logic [ecgrp_pkg::THR_W-1:0] thr_r;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [MT_W-1:0]   prev_r, prev_nxt, cur_r, cur_nxt;
  logic [AW-1:0]            cur_pos_r, cur_pos_nxt;
  logic [AW-1:0]            plat_r, plat_nxt;

  logic                             out_valid_r, out_valid_nxt;
  ecgrp_pkg::status_t               out_status_r, out_status_nxt;
  logic [ecgrp_pkg::PEAK_IDX_W-1:0] out_peak_r, out_peak_nxt;
  ecgrp_pkg::tod_t                  out_tod_r, out_tod_nxt;

  logic                   accept, store_beat, mmt_go;
  logic [AW-1:0]          wp_inc, pos_inc, rd_addr, from_pos;
  logic [AW:0]            from_sum;
  logic [ecgrp_pkg::SAMPLE_W-1:0] rd_data;
  ecgrp_pkg::mmt_rsp_t    rsp;
  ecgrp_pkg::tod_t        tod;
  logic signed [MT_W-1:0] m_in, neg_thr;
  logic                   warm, hit_strict, hit_plat, mark_plat, last_pos;
  logic [31:0]            where_w;

  assign accept     = start && (state_r == ecgrp_pkg::S_IDLE);
  assign store_beat = accept && !in_opcode;

  assign wp_inc  = (wp_r == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign pos_inc = (pos_r == AW'(BUFFER_DEPTH - 1)) ? '0 : pos_r + 1'b1;

  // first transform position: ((wp + 1) mod depth + margin) mod depth
  assign from_sum = {1'b0, wp_inc} + (AW+1)'(MARG_MOD);
  assign from_pos = (from_sum >= DEPTH_X) ? AW'(from_sum - DEPTH_X) : from_sum[AW-1:0];

  assign m_in    = rsp.m;
  assign neg_thr = -$signed({{(MT_W - ecgrp_pkg::THR_W){1'b0}}, thr_r});

  // candidate test; m_in is the right neighbor of the current candidate
  always_comb begin
    warm       = (cnt_r != '0) && (cnt_r != CW'(1));
    hit_strict = warm && (prev_r > cur_r) && (cur_r < m_in) && (cur_r < neg_thr);
    hit_plat   = warm && (prev_r == cur_r) && (cur_r < m_in) && (cur_r < neg_thr);
    mark_plat  = warm && (prev_r > cur_r) && (cur_r == m_in);
    last_pos   = (cnt_r == CW'(SEARCH_SPAN));
    where_w    = hit_strict ? 32'(cur_pos_r) : 32'(plat_r);
  end

  ecgrp_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_beat),
    .wr_addr (wp_r),
    .wr_data (in_sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ecgrp_mmt #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .HALF_WINDOW  (HALF_WINDOW)
  ) u_mmt (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mmt_go),
    .pos     (pos_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .rsp     (rsp)
  );

  ecgrp_tod #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_tod (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (store_beat),
    .tod   (tod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecgrp_pkg::S_IDLE: begin
        if (start && in_opcode && !learning_r) begin
          state_nxt = ecgrp_pkg::S_LAUNCH;
        end
      end
      ecgrp_pkg::S_LAUNCH: state_nxt = ecgrp_pkg::S_WAIT;
      ecgrp_pkg::S_WAIT: begin
        if (rsp.done) begin
          if (hit_strict || hit_plat || last_pos) begin
            state_nxt = ecgrp_pkg::S_IDLE;
          end else begin
            state_nxt = ecgrp_pkg::S_LAUNCH;
          end
        end
      end
      default: state_nxt = ecgrp_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    wp_nxt         = wp_r;
    learning_nxt   = learning_r;
    wrapped_nxt    = wrapped_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    cur_pos_nxt    = cur_pos_r;
    plat_nxt       = plat_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_peak_nxt   = out_peak_r;
    out_tod_nxt    = out_tod_r;
    case (state_r)
      ecgrp_pkg::S_IDLE: begin
        if (start) begin
          if (!in_opcode) begin
            wp_nxt        = wp_inc;
            learning_nxt  = learning_r && (wp_inc != '0);
            if (wp_inc == '0) wrapped_nxt = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = (learning_r && (wp_inc != '0)) ? ecgrp_pkg::ST_LEARNING
                                                            : ecgrp_pkg::ST_STORED;
            out_peak_nxt   = '0;
            out_tod_nxt    = '0;
          end else if (learning_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ecgrp_pkg::ST_LEARNING;
            out_peak_nxt   = '0;
            out_tod_nxt    = '0;
          end else begin
            pos_nxt = from_pos;
            cnt_nxt = '0;
          end
        end
      end
      ecgrp_pkg::S_WAIT: begin
        if (rsp.done) begin
          if (cnt_r == '0) begin
            prev_nxt = m_in;
            pos_nxt  = pos_inc;
            cnt_nxt  = cnt_r + 1'b1;
          end else if (cnt_r == CW'(1)) begin
            cur_nxt     = m_in;
            cur_pos_nxt = pos_r;
            plat_nxt    = pos_r;
            pos_nxt     = pos_inc;
            cnt_nxt     = cnt_r + 1'b1;
          end else if (hit_strict || hit_plat) begin
            wrapped_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ecgrp_pkg::ST_PEAK;
            out_peak_nxt   = where_w[ecgrp_pkg::PEAK_IDX_W-1:0];
            out_tod_nxt    = '0;
          end else begin
            if (mark_plat) plat_nxt = cur_pos_r;
            prev_nxt    = cur_r;
            cur_nxt     = m_in;
            cur_pos_nxt = pos_r;
            if (last_pos) begin
              out_valid_nxt = 1'b1;
              out_peak_nxt  = '0;
              if (wrapped_r) begin
                wrapped_nxt    = 1'b0;
                out_status_nxt = ecgrp_pkg::ST_OVERDUE;
                out_tod_nxt    = tod;
              end else begin
                out_status_nxt = ecgrp_pkg::ST_NO_PEAK;
                out_tod_nxt    = '0;
              end
            end else begin
              pos_nxt = pos_inc;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy                 = (state_r != ecgrp_pkg::S_IDLE);
    mmt_go               = (state_r == ecgrp_pkg::S_LAUNCH);
    cfg_ready            = 1'b1;
    out_valid            = out_valid_r;
    out_status           = out_status_r;
    out_peak_index       = out_peak_r;
    out_hour_of_day      = out_tod_r.hour;
    out_minute_of_hour   = out_tod_r.minute;
    out_second_of_minute = out_tod_r.second;
    out_tick_of_second   = out_tod_r.tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecgrp_pkg::S_IDLE;
      wp_r        <= '0;
      learning_r  <= 1'b1;
      wrapped_r   <= 1'b0;
      thr_r       <= ecgrp_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      learning_r  <= learning_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_peak_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    cur_pos_r    <= cur_pos_nxt;
    plat_r       <= plat_nxt;
    out_status_r <= out_status_nxt;
    out_peak_r   <= out_peak_nxt;
    out_tod_r    <= out_tod_nxt;
  end

  // every result beat comes from an accepted beat or a finishing scan
  `ECGRP_ASSERT(a_result_has_source, clk, rst_n, out_valid |-> ($past(start) || $past(busy)), "result beat without a source")
  // a scan always ends in a result beat
  `ECGRP_ASSERT(a_scan_ends_with_result, clk, rst_n, ($past(busy) && !busy && $past(rst_n)) |-> out_valid, "scan ended without result")
  // store beats never occupy the sequencer
  `ECGRP_ASSERT(a_store_not_busy, clk, rst_n, (start && !busy && !in_opcode) |=> !busy, "store beat raised busy")
  // learning status only while the store has not wrapped
  `ECGRP_ASSERT(a_learning_status, clk, rst_n, (out_valid && (out_status == ecgrp_pkg::ST_LEARNING)) |-> learning_r, "learning status after wrap")
  // reset leaves the block idle with no result pending
  `ECGRP_ASSERT_NR(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule
